// ----- rtl/sktt_pkg.sv -----
// ----------------------------------------------------------------------------
// sktt_pkg
// Shared types, widths and constants of the scalar temperature tracker.
// ----------------------------------------------------------------------------
package sktt_pkg;

  // Fraction bits of the internal gain.
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_W         = GAIN_FRAC_BITS + 1;

  localparam int TEMP_W     = 16;
  localparam int VAR_W      = 24;
  localparam int OGAIN_W    = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Serial divider: numerator is p, denominator is p + r.
  localparam int DIV_DEN_W = VAR_W + 1;
  localparam int DIV_REM_W = VAR_W + 2;
  localparam int DIV_CNT_W = $clog2(GAIN_W + 1);

  // Shared multiplier operands, signed.
  localparam int MUL_A_W = (GAIN_W + 1 > 33) ? GAIN_W + 1 : 33;
  localparam int MUL_B_W = VAR_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Estimate accumulator at scale 2^(8 + GAIN_FRAC_BITS) divided by 256.
  localparam int ACC_W = GAIN_FRAC_BITS + 27;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;

  localparam logic [VAR_W-1:0]  RST_MEAS_VAR        = VAR_W'(4096);
  localparam logic [VAR_W-1:0]  RST_PROCESS_VAR     = VAR_W'(256);
  localparam logic [TEMP_W-1:0] RST_SAMPLE_INTERVAL = TEMP_W'(1280);
  localparam logic [TEMP_W-1:0] RST_HEAT_RATE       = TEMP_W'(0);
  localparam logic [VAR_W-1:0]  RST_RATE_VAR        = VAR_W'(0);
  localparam logic [TEMP_W-1:0] RST_INIT_ESTIMATE   = TEMP_W'(4096);
  localparam logic [VAR_W-1:0]  RST_INIT_VARIANCE   = VAR_W'(25600);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEAS_VAR        = 3'd0,
    REG_PROCESS_VAR     = 3'd1,
    REG_SAMPLE_INTERVAL = 3'd2,
    REG_HEAT_RATE       = 3'd3,
    REG_RATE_VAR        = 3'd4,
    REG_INIT_ESTIMATE   = 3'd5,
    REG_INIT_VARIANCE   = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_MUL_TR,
    S_MUL_KD,
    S_MUL_KP,
    S_MUL_TT,
    S_MUL_TTV,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [TEMP_W-1:0] measurement;
    logic              first;
  } in_t;

  typedef struct packed {
    logic [TEMP_W-1:0]  estimate;
    logic [VAR_W-1:0]   variance;
    logic [OGAIN_W-1:0] gain;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/sktt_div.sv -----
// ----------------------------------------------------------------------------
// sktt_div
// Restoring divider that forms floor(num * 2^GAIN_FRAC_BITS / den), one
// quotient bit per cycle, for num <= den.
// ----------------------------------------------------------------------------
module sktt_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [sktt_pkg::VAR_W-1:0]        num_i,
  input  logic [sktt_pkg::DIV_DEN_W-1:0]    den_i,
  output logic [sktt_pkg::GAIN_W-1:0]       quot_o,
  output sktt_pkg::div_stat_t               stat_o
);

  logic                               busy_q;
  logic [sktt_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [sktt_pkg::DIV_REM_W-1:0]     rem_q;
  logic [sktt_pkg::DIV_DEN_W-1:0]     den_q;
  logic [sktt_pkg::GAIN_W-1:0]        quot_q;
  logic                               ge;
  logic [sktt_pkg::DIV_REM_W-1:0]     diff;
  logic [sktt_pkg::DIV_REM_W-1:0]     rem_sel;
  logic                               step;

  assign step = busy_q && (cnt_q != '0);

  always_comb begin
    ge      = rem_q >= sktt_pkg::DIV_REM_W'(den_q);
    diff    = rem_q - sktt_pkg::DIV_REM_W'(den_q);
    rem_sel = ge ? diff : rem_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= sktt_pkg::DIV_CNT_W'(sktt_pkg::GAIN_W);
    end else if (step) begin
      cnt_q <= cnt_q - sktt_pkg::DIV_CNT_W'(1);
    end else if (busy_q) begin
      busy_q <= 1'b0;
    end
  end

  // The first step yields the integer bit, the rest the fraction bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= sktt_pkg::DIV_REM_W'(num_i);
      den_q  <= den_i;
      quot_q <= '0;
    end else if (step) begin
      rem_q  <= {rem_sel[sktt_pkg::DIV_REM_W-2:0], 1'b0};
      quot_q <= {quot_q[sktt_pkg::GAIN_W-2:0], ge};
    end
  end

  assign quot_o      = quot_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (cnt_q == '0);

endmodule

// ----- rtl/sktt_mul.sv -----
// ----------------------------------------------------------------------------
// sktt_mul
// Shared signed multiplier with a registered product that holds while the
// enable is low.
// ----------------------------------------------------------------------------
module sktt_mul (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [sktt_pkg::MUL_A_W-1:0]  a_i,
  input  logic signed [sktt_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [sktt_pkg::MUL_P_W-1:0]  prod_o
);

  logic signed [sktt_pkg::MUL_P_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= sktt_pkg::MUL_P_W'(a_i) * sktt_pkg::MUL_P_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/scalar_kalman_temperature_tracker_core.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_temperature_tracker_core
// Fixed-point scalar Kalman filter for a temperature with a constant rate.
// ----------------------------------------------------------------------------
//  Channel  | Signals                               | Direction
//  ---------+---------------------------------------+----------
//  input    | in_valid_i, in_ready_o, in_data_i     | to core
//  output   | out_valid_o, out_ready_i, out_data_o  | from core
//  config   | cfg_valid_i, cfg_ready_o, cfg_index_i,| to core
//           | cfg_data_i                            |
//
// A measurement passes from transfer to result through a load cycle, the
// serial gain divider, five passes through the shared multiplier and a
// finishing cycle. The input is ready only while the sequencer is idle, so a
// new item is taken only once the previous one has left the finishing cycle.
// A result waits in the output register; a stalled output holds the
// sequencer in its finishing cycle with the multiplier product frozen.
// Reset loads the register defaults.
// ----------------------------------------------------------------------------
module scalar_kalman_temperature_tracker_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  sktt_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output sktt_pkg::out_t                      out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sktt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sktt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int G      = sktt_pkg::GAIN_FRAC_BITS;
  localparam int TT_W   = 32;
  localparam int TTV_W  = TT_W + sktt_pkg::VAR_W;
  localparam int T2_W   = TTV_W - 16;
  localparam int GSH_R  = (G >= 16) ? G - 16 : 0;
  localparam int GSH_L  = (G >= 16) ? 0 : 16 - G;
  localparam int GK_W   = sktt_pkg::GAIN_W + GSH_L;

  // Configuration registers.
  logic [sktt_pkg::VAR_W-1:0]  meas_var_q, process_var_q, rate_var_q, init_variance_q;
  logic [sktt_pkg::TEMP_W-1:0] sample_interval_q, heat_rate_q, init_estimate_q;

  // Filter state and working registers.
  logic [sktt_pkg::TEMP_W-1:0]     est_q;
  logic [sktt_pkg::VAR_W-1:0]      var_q;
  sktt_pkg::state_e                state_q, state_d;
  sktt_pkg::in_t                   item_q;
  logic                            s_zero_q;
  logic [sktt_pkg::GAIN_W-1:0]     k_q;
  logic signed [sktt_pkg::ACC_W-1:0] acc_q;
  logic [sktt_pkg::VAR_W-1:0]      t1_q;
  logic                            out_valid_q;
  sktt_pkg::out_t                  out_data_q;

  // Shared units.
  logic                                div_start;
  logic [sktt_pkg::GAIN_W-1:0]         div_quot;
  sktt_pkg::div_stat_t                 div_stat;
  logic                                mul_en;
  logic signed [sktt_pkg::MUL_A_W-1:0] mul_a;
  logic signed [sktt_pkg::MUL_B_W-1:0] mul_b;
  logic signed [sktt_pkg::MUL_P_W-1:0] prod_q;

  // Combinational datapath.
  logic [sktt_pkg::TEMP_W-1:0]       est_eff;
  logic [sktt_pkg::VAR_W-1:0]        var_eff;
  logic [sktt_pkg::DIV_DEN_W-1:0]    sum_pr;
  logic [sktt_pkg::TEMP_W:0]         meas_diff;
  logic signed [sktt_pkg::ACC_W-1:0] tr_term;
  logic signed [sktt_pkg::ACC_W-1:0] est_shift;
  logic [sktt_pkg::TEMP_W-1:0]       est_new;
  logic [T2_W-1:0]                   t2_full;
  logic [sktt_pkg::VAR_W-1:0]        t2_sat;
  logic [sktt_pkg::VAR_W+1:0]        var_sum;
  logic [sktt_pkg::VAR_W-1:0]        var_new;
  logic [GK_W-1:0]                   gain_wide;
  logic [sktt_pkg::OGAIN_W-1:0]      gain_new;
  logic                              fin_go;

  sktt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (var_eff),
    .den_i   (sum_pr),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  // The finishing cycle reads the last product, so it must not move there.
  assign mul_en = (state_q != sktt_pkg::S_FIN);

  sktt_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod_q)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_var_q        <= sktt_pkg::RST_MEAS_VAR;
      process_var_q     <= sktt_pkg::RST_PROCESS_VAR;
      sample_interval_q <= sktt_pkg::RST_SAMPLE_INTERVAL;
      heat_rate_q       <= sktt_pkg::RST_HEAT_RATE;
      rate_var_q        <= sktt_pkg::RST_RATE_VAR;
      init_estimate_q   <= sktt_pkg::RST_INIT_ESTIMATE;
      init_variance_q   <= sktt_pkg::RST_INIT_VARIANCE;
    end else if (cfg_valid_i) begin
      unique case (sktt_pkg::cfg_reg_e'(cfg_index_i))
        sktt_pkg::REG_MEAS_VAR:        meas_var_q        <= cfg_data_i;
        sktt_pkg::REG_PROCESS_VAR:     process_var_q     <= cfg_data_i;
        sktt_pkg::REG_SAMPLE_INTERVAL: sample_interval_q <= cfg_data_i[15:0];
        sktt_pkg::REG_HEAT_RATE:       heat_rate_q       <= cfg_data_i[15:0];
        sktt_pkg::REG_RATE_VAR:        rate_var_q        <= cfg_data_i;
        sktt_pkg::REG_INIT_ESTIMATE:   init_estimate_q   <= cfg_data_i[15:0];
        sktt_pkg::REG_INIT_VARIANCE:   init_variance_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A first item restarts the track from the init registers.
  always_comb begin
    est_eff   = item_q.first ? init_estimate_q : est_q;
    var_eff   = item_q.first ? init_variance_q : var_q;
    sum_pr    = sktt_pkg::DIV_DEN_W'(var_eff) + sktt_pkg::DIV_DEN_W'(meas_var_q);
    meas_diff = {1'b0, item_q.measurement} - {1'b0, est_q};
    tr_term   = sktt_pkg::ACC_W'(prod_q) <<< (G - 8);
  end

  // Final saturation of the estimate, variance and output gain.
  always_comb begin
    est_shift = acc_q >>> G;
    if (acc_q < 0) begin
      est_new = '0;
    end else if (est_shift > sktt_pkg::ACC_W'(16'hFFFF)) begin
      est_new = '1;
    end else begin
      est_new = est_shift[sktt_pkg::TEMP_W-1:0];
    end
    t2_full = prod_q[TTV_W-1:16];
    t2_sat  = (t2_full > T2_W'({sktt_pkg::VAR_W{1'b1}})) ? '1 : t2_full[sktt_pkg::VAR_W-1:0];
    var_sum = (sktt_pkg::VAR_W+2)'(t1_q) + (sktt_pkg::VAR_W+2)'(t2_sat)
            + (sktt_pkg::VAR_W+2)'(process_var_q);
    var_new = (var_sum > (sktt_pkg::VAR_W+2)'({sktt_pkg::VAR_W{1'b1}})) ? '1
            : var_sum[sktt_pkg::VAR_W-1:0];
    gain_wide = (GK_W'(k_q) << GSH_L) >> GSH_R;
    gain_new  = (gain_wide > GK_W'(65536)) ? sktt_pkg::OGAIN_W'(65536)
              : gain_wide[sktt_pkg::OGAIN_W-1:0];
  end

  assign fin_go = (state_q == sktt_pkg::S_FIN) && (!out_valid_q || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sktt_pkg::S_IDLE:    if (in_valid_i) state_d = sktt_pkg::S_LOAD;
      sktt_pkg::S_LOAD:    state_d = sktt_pkg::S_DIV;
      sktt_pkg::S_DIV:     if (div_stat.done) state_d = sktt_pkg::S_MUL_TR;
      sktt_pkg::S_MUL_TR:  state_d = sktt_pkg::S_MUL_KD;
      sktt_pkg::S_MUL_KD:  state_d = sktt_pkg::S_MUL_KP;
      sktt_pkg::S_MUL_KP:  state_d = sktt_pkg::S_MUL_TT;
      sktt_pkg::S_MUL_TT:  state_d = sktt_pkg::S_MUL_TTV;
      sktt_pkg::S_MUL_TTV: state_d = sktt_pkg::S_FIN;
      sktt_pkg::S_FIN:     if (fin_go) state_d = sktt_pkg::S_IDLE;
      default:             state_d = sktt_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, divider start and operands of the shared multiplier.
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      sktt_pkg::S_IDLE: in_ready_o = 1'b1;
      sktt_pkg::S_LOAD: div_start = 1'b1;
      sktt_pkg::S_MUL_TR: begin
        mul_a = sktt_pkg::MUL_A_W'(sample_interval_q);
        mul_b = sktt_pkg::MUL_B_W'($signed(heat_rate_q));
      end
      sktt_pkg::S_MUL_KD: begin
        mul_a = sktt_pkg::MUL_A_W'(k_q);
        mul_b = sktt_pkg::MUL_B_W'($signed(meas_diff));
      end
      sktt_pkg::S_MUL_KP: begin
        mul_a = sktt_pkg::MUL_A_W'(sktt_pkg::GAIN_ONE - k_q);
        mul_b = sktt_pkg::MUL_B_W'(var_q);
      end
      sktt_pkg::S_MUL_TT: begin
        mul_a = sktt_pkg::MUL_A_W'(sample_interval_q);
        mul_b = sktt_pkg::MUL_B_W'(sample_interval_q);
      end
      sktt_pkg::S_MUL_TTV: begin
        // The product register holds t*t here.
        mul_a = sktt_pkg::MUL_A_W'(prod_q[TT_W-1:0]);
        mul_b = sktt_pkg::MUL_B_W'(rate_var_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sktt_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      est_q       <= sktt_pkg::RST_INIT_ESTIMATE;
      var_q       <= sktt_pkg::RST_INIT_VARIANCE;
    end else begin
      state_q <= state_d;
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == sktt_pkg::S_LOAD) begin
        est_q <= est_eff;
        var_q <= var_eff;
      end else if (fin_go) begin
        est_q <= est_new;
        var_q <= var_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (state_q == sktt_pkg::S_LOAD) begin
      s_zero_q <= (sum_pr == '0);
    end
    if ((state_q == sktt_pkg::S_DIV) && div_stat.done) begin
      k_q <= s_zero_q ? '0 : div_quot;
    end
    unique case (state_q)
      sktt_pkg::S_MUL_TR: acc_q <= sktt_pkg::ACC_W'({est_q, {G{1'b0}}});
      sktt_pkg::S_MUL_KD: acc_q <= acc_q + tr_term;
      sktt_pkg::S_MUL_KP: acc_q <= acc_q + sktt_pkg::ACC_W'(prod_q);
      sktt_pkg::S_MUL_TT: t1_q  <= prod_q[G+sktt_pkg::VAR_W-1:G];
      default: ;
    endcase
    if (fin_go) begin
      out_data_q.estimate <= est_new;
      out_data_q.variance <= var_new;
      out_data_q.gain     <= gain_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Only an idle sequencer takes an item, and it starts with the load cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == sktt_pkg::S_LOAD))
    else $error("accepted item did not enter the load cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> !in_ready_o)
    else $error("input ready while the divider runs");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == sktt_pkg::S_DIV) && div_stat.done && !s_zero_q)
      |-> (div_quot <= sktt_pkg::GAIN_ONE))
    else $error("gain quotient above one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.gain <= sktt_pkg::OGAIN_W'(65536)))
    else $error("output gain out of range");

endmodule
